// ===== sv/tgbs_pkg.sv =====
// ============================================================================
// Two-model Gaussian background subtractor package
// Shared constants, data types and small helper functions for the core.
// ============================================================================
`default_nettype none

package tgbs_pkg;

    localparam int PIXELS = 131072;
    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int POS_W  = 17;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MEAN_RATE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_RATE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_RATE      = 3'd4;

    localparam logic [7:0]  MATCH_THRESHOLD_RESET  = 8'd40;
    localparam logic [15:0] WEIGHT_THRESHOLD_RESET = 16'd45875;
    localparam logic [15:0] MEAN_RATE_RESET        = 16'd655;
    localparam logic [15:0] VARIANCE_RATE_RESET    = 16'd655;
    localparam logic [15:0] WEIGHT_RATE_RESET      = 16'd655;

    localparam logic [16:0] WEIGHT_ONE    = 17'd65536;
    localparam logic [15:0] MEAN_MAX      = 16'hFFFF;
    localparam logic [22:0] VARIANCE_MAX  = 23'h7FFFFF;
    localparam logic [22:0] SEED_VARIANCE = 23'd12800;

    localparam int STAGES     = 7;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [22:0] variance;
        logic [15:0] mean;
        logic [16:0] weight;
    } model_t;

    typedef model_t [1:0] entry_t;

    typedef struct packed {
        logic [7:0]       value;
        logic [POS_W-1:0] pos;
        logic             seed;
        logic             in_range;
    } item_t;

    typedef struct packed {
        logic             foreground;
        logic             mask_valid;
        logic [POS_W-1:0] position;
    } result_t;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [16:0] clamp_weight(input logic [16:0] w);
        return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/two_gaussian_background_subtractor_core.sv =====
// ============================================================================
// Two-model Gaussian background subtractor core
// Per-pixel read-modify-write of two Gaussian models held in one memory.
// ============================================================================
// The core takes one pixel per clock while no position hazard or full output
// queue holds input off, and returns one mask transaction per pixel, in order.
// A pixel is read from the model memory when it is taken, goes through a
// seven-stage update pipeline and is then written back and queued for output.
// A pixel whose position equals that of one still in the update pipeline is
// held off until that one has been written back; distinct positions flow at one
// per clock while the queue has room. A sixteen-entry output queue lets input
// continue while results wait. The model memory gets no clearing pass after
// reset; the first frame must seed every entry later read, which the core does not enforce.
`default_nettype none

module two_gaussian_background_subtractor_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          pixel_value,
    input  wire logic [tgbs_pkg::POS_W-1:0]          pixel_position,
    input  wire logic                                frame_end,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     foreground,
    output logic                                     mask_valid,
    output logic [tgbs_pkg::POS_W-1:0]               position_out,
    input  wire logic                                cfg_write,
    input  wire logic [tgbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tgbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int S = tgbs_pkg::STAGES;

    logic [7:0]  match_threshold_reg;
    logic [15:0] weight_threshold_reg;
    logic [15:0] mean_rate_reg;
    logic [15:0] variance_rate_reg;
    logic [15:0] weight_rate_reg;
    logic [15:0] t2_reg;
    logic        seeded_reg;

    logic [S:1]                   stage_valid_reg;
    tgbs_pkg::item_t              item_reg [1:S];
    tgbs_pkg::entry_t             rd_data_reg;
    tgbs_pkg::entry_t             entry_reg [2:S];
    tgbs_pkg::entry_t             model_mem [tgbs_pkg::PIXELS];

    logic [31:0] d2_reg [2];
    logic [31:0] d2_next [2];
    logic [38:0] lim_reg [2];
    logic [38:0] lim_next [2];
    logic        hit_reg [3:S];
    logic        sel_reg [3:S];
    logic        hit_next;
    logic        sel_next;
    logic        hit_a;
    logic        hit_b;
    logic [32:0] pm_a_reg;
    logic [32:0] pm_a_next;
    logic [31:0] pm_b_reg;
    logic [31:0] pm_b_next;
    logic [39:0] pv_reg [4:S];
    logic [39:0] pv_next;
    logic [33:0] pw_reg [2];
    logic [33:0] pw_next [2];
    logic [15:0] nm_reg [5:S];
    logic [15:0] nm_next;
    logic [15:0] dev_n_reg;
    logic [15:0] dev_n_next;
    logic [1:0][16:0] neww_reg [5:S];
    logic [1:0][16:0] neww_next;
    logic        fg_reg [5:S];
    logic        fg_next;
    logic [31:0] d2n_reg;
    logic [31:0] d2n_next;
    logic [47:0] pd_reg;
    logic [47:0] pd_next;

    logic [16:0] mean_keep;
    logic [16:0] var_keep;
    logic [16:0] w_keep;
    logic [15:0] m_sel;
    logic [22:0] v_sel;
    logic [33:0] msum;
    logic [17:0] nm_wide;
    logic [15:0] target4;
    logic [1:0][16:0] w_decayed;
    logic [17:0] reward_sum;
    logic [16:0] w_reward;
    logic        w_update;
    logic [49:0] vsum;
    logic [24:0] nv_wide;
    logic [22:0] nv;
    logic [15:0] target7;
    tgbs_pkg::entry_t  new_entry;
    tgbs_pkg::result_t result;

    logic                           hazard;
    logic                           accept;
    logic                           out_accept;
    logic                           mem_we;
    logic [tgbs_pkg::ADDR_W-1:0]    mem_raddr;
    logic [tgbs_pkg::ADDR_W-1:0]    mem_waddr;

    tgbs_pkg::result_t              fifo_mem [tgbs_pkg::FIFO_DEPTH];
    logic [tgbs_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [tgbs_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [tgbs_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [tgbs_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [tgbs_pkg::OCC_W-1:0]     fifo_count_reg;
    logic [tgbs_pkg::OCC_W-1:0]     fifo_count_next;
    logic [tgbs_pkg::OCC_W-1:0]     occ_reg;
    logic [tgbs_pkg::OCC_W-1:0]     occ_next;
    logic                           seeded_next;

    // A new pixel may not read an entry that an earlier pixel has yet to write back.
    always_comb
    begin
        hazard = 1'b0;
        for (int i = 1; i <= S; i++)
        begin
            if (stage_valid_reg[i] && (item_reg[i].pos == pixel_position))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign in_ready   = (occ_reg < tgbs_pkg::OCC_W'(tgbs_pkg::FIFO_DEPTH)) && !hazard;
    assign accept     = in_valid && in_ready;
    assign out_valid  = (fifo_count_reg != '0);
    assign out_accept = out_valid && out_ready;
    assign mem_raddr  = tgbs_pkg::ADDR_W'(pixel_position);
    assign mem_waddr  = tgbs_pkg::ADDR_W'(item_reg[S].pos);
    assign mem_we     = stage_valid_reg[S] && item_reg[S].in_range;

    assign seeded_next     = seeded_reg || (accept && frame_end);
    assign occ_next        = occ_reg + tgbs_pkg::OCC_W'(accept) - tgbs_pkg::OCC_W'(out_accept);
    assign fifo_count_next = fifo_count_reg + tgbs_pkg::OCC_W'(stage_valid_reg[S])
                             - tgbs_pkg::OCC_W'(out_accept);
    assign wr_ptr_next     = wr_ptr_reg + tgbs_pkg::FIFO_AW'(stage_valid_reg[S]);
    assign rd_ptr_next     = rd_ptr_reg + tgbs_pkg::FIFO_AW'(out_accept);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_threshold_reg  <= tgbs_pkg::MATCH_THRESHOLD_RESET;
            weight_threshold_reg <= tgbs_pkg::WEIGHT_THRESHOLD_RESET;
            mean_rate_reg        <= tgbs_pkg::MEAN_RATE_RESET;
            variance_rate_reg    <= tgbs_pkg::VARIANCE_RATE_RESET;
            weight_rate_reg      <= tgbs_pkg::WEIGHT_RATE_RESET;
            t2_reg               <= 16'(tgbs_pkg::MATCH_THRESHOLD_RESET)
                                    * 16'(tgbs_pkg::MATCH_THRESHOLD_RESET);
            seeded_reg           <= 1'b0;
            stage_valid_reg      <= '0;
            occ_reg              <= '0;
            fifo_count_reg       <= '0;
            wr_ptr_reg           <= '0;
            rd_ptr_reg           <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    tgbs_pkg::REG_MATCH_THRESHOLD:  match_threshold_reg  <= cfg_data[7:0];
                    tgbs_pkg::REG_WEIGHT_THRESHOLD: weight_threshold_reg <= cfg_data;
                    tgbs_pkg::REG_MEAN_RATE:        mean_rate_reg        <= cfg_data;
                    tgbs_pkg::REG_VARIANCE_RATE:    variance_rate_reg    <= cfg_data;
                    tgbs_pkg::REG_WEIGHT_RATE:      weight_rate_reg      <= cfg_data;
                    default:                        ;
                endcase
            end
            t2_reg          <= 16'(match_threshold_reg) * 16'(match_threshold_reg);
            seeded_reg      <= seeded_next;
            stage_valid_reg <= {stage_valid_reg[S-1:1], accept};
            occ_reg         <= occ_next;
            fifo_count_reg  <= fifo_count_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= model_mem[mem_raddr];
        if (mem_we)
        begin
            model_mem[mem_waddr] <= new_entry;
        end
    end

    // Stage 1: squared deviations and match limits for both models.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            d2_next[k]  = {16'b0, tgbs_pkg::abs_diff(rd_data_reg[k].mean,
                                                     {item_reg[1].value, 8'h00})}
                          * {16'b0, tgbs_pkg::abs_diff(rd_data_reg[k].mean,
                                                       {item_reg[1].value, 8'h00})};
            lim_next[k] = 39'(t2_reg) * 39'(rd_data_reg[k].variance);
        end
    end

    // Stage 2: the first weighted model within the threshold wins, else the lighter one.
    always_comb
    begin
        hit_a    = (entry_reg[2][0].weight != '0)
                   && ({8'b0, d2_reg[0]} <= {lim_reg[0], 1'b0});
        hit_b    = (entry_reg[2][1].weight != '0)
                   && ({8'b0, d2_reg[1]} <= {lim_reg[1], 1'b0});
        hit_next = hit_a || hit_b;
        if (hit_a)
        begin
            sel_next = 1'b0;
        end
        else if (hit_b)
        begin
            sel_next = 1'b1;
        end
        else
        begin
            sel_next = (entry_reg[2][0].weight > entry_reg[2][1].weight);
        end
    end

    // Stage 3: products for the mean, variance and weight updates.
    always_comb
    begin
        mean_keep = tgbs_pkg::WEIGHT_ONE - {1'b0, mean_rate_reg};
        var_keep  = tgbs_pkg::WEIGHT_ONE - {1'b0, variance_rate_reg};
        w_keep    = tgbs_pkg::WEIGHT_ONE - {1'b0, weight_rate_reg};
        m_sel     = entry_reg[3][sel_reg[3]].mean;
        v_sel     = entry_reg[3][sel_reg[3]].variance;
        pm_a_next = 33'(m_sel) * 33'(mean_keep);
        pm_b_next = 32'({item_reg[3].value, 8'h00}) * 32'(mean_rate_reg);
        pv_next   = 40'(v_sel) * 40'(var_keep);
        for (int k = 0; k < 2; k++)
        begin
            pw_next[k] = 34'(tgbs_pkg::clamp_weight(entry_reg[3][k].weight)) * 34'(w_keep);
        end
    end

    // Stage 4: new mean, its deviation, and the new weights with the decision.
    always_comb
    begin
        target4  = {item_reg[4].value, 8'h00};
        msum     = {1'b0, pm_a_reg} + {2'b0, pm_b_reg} + 34'd32768;
        nm_wide  = msum[33:16];
        if (hit_reg[4])
        begin
            nm_next = (nm_wide > 18'(tgbs_pkg::MEAN_MAX)) ? tgbs_pkg::MEAN_MAX : nm_wide[15:0];
        end
        else
        begin
            nm_next = target4;
        end
        dev_n_next = tgbs_pkg::abs_diff(nm_next, target4);

        for (int k = 0; k < 2; k++)
        begin
            w_decayed[k] = pw_reg[k][32:16];
        end
        reward_sum = {1'b0, w_decayed[sel_reg[4]]} + {2'b0, weight_rate_reg};
        w_reward   = (reward_sum > {1'b0, tgbs_pkg::WEIGHT_ONE}) ? tgbs_pkg::WEIGHT_ONE
                                                                 : reward_sum[16:0];
        w_update   = hit_reg[4] || (entry_reg[4][sel_reg[4]].weight != '0);
        for (int k = 0; k < 2; k++)
        begin
            if (!w_update)
            begin
                neww_next[k] = entry_reg[4][k].weight;
            end
            else if (1'(k) == sel_reg[4])
            begin
                neww_next[k] = w_reward;
            end
            else
            begin
                neww_next[k] = w_decayed[k];
            end
        end
        fg_next = !(neww_next[sel_reg[4]] > {1'b0, weight_threshold_reg});
    end

    // Stages 5 and 6: squared deviation from the new mean, scaled by the rate.
    assign d2n_next = 32'(dev_n_reg) * 32'(dev_n_reg);
    assign pd_next  = 48'(d2n_reg) * 48'(variance_rate_reg);

    // Stage 7: new variance, assembled entry and mask transaction.
    always_comb
    begin
        target7 = {item_reg[S].value, 8'h00};
        vsum    = {1'b0, pv_reg[S], 9'b0} + {2'b0, pd_reg} + 50'd16777216;
        nv_wide = vsum[49:25];
        nv      = (nv_wide > 25'(tgbs_pkg::VARIANCE_MAX)) ? tgbs_pkg::VARIANCE_MAX
                                                          : nv_wide[22:0];
        if (item_reg[S].seed)
        begin
            new_entry[0].weight   = tgbs_pkg::WEIGHT_ONE;
            new_entry[0].mean     = target7;
            new_entry[0].variance = tgbs_pkg::SEED_VARIANCE;
            new_entry[1].weight   = '0;
            new_entry[1].mean     = target7;
            new_entry[1].variance = tgbs_pkg::SEED_VARIANCE;
        end
        else
        begin
            new_entry                       = entry_reg[S];
            new_entry[0].weight             = neww_reg[S][0];
            new_entry[1].weight             = neww_reg[S][1];
            new_entry[sel_reg[S]].mean      = nm_reg[S];
            new_entry[sel_reg[S]].variance  = hit_reg[S] ? nv : tgbs_pkg::SEED_VARIANCE;
        end
        result.mask_valid = !item_reg[S].seed && item_reg[S].in_range;
        result.foreground = result.mask_valid && fg_reg[S];
        result.position   = item_reg[S].pos;
    end

    always_ff @(posedge clk)
    begin
        item_reg[1].value    <= pixel_value;
        item_reg[1].pos      <= pixel_position;
        item_reg[1].seed     <= !seeded_reg;
        item_reg[1].in_range <= (32'(pixel_position) < 32'(tgbs_pkg::PIXELS));
        for (int i = 2; i <= S; i++)
        begin
            item_reg[i] <= item_reg[i-1];
        end

        entry_reg[2] <= rd_data_reg;
        for (int i = 3; i <= S; i++)
        begin
            entry_reg[i] <= entry_reg[i-1];
        end

        d2_reg  <= d2_next;
        lim_reg <= lim_next;

        hit_reg[3] <= hit_next;
        sel_reg[3] <= sel_next;
        for (int i = 4; i <= S; i++)
        begin
            hit_reg[i] <= hit_reg[i-1];
            sel_reg[i] <= sel_reg[i-1];
        end

        pm_a_reg  <= pm_a_next;
        pm_b_reg  <= pm_b_next;
        pw_reg    <= pw_next;
        pv_reg[4] <= pv_next;
        for (int i = 5; i <= S; i++)
        begin
            pv_reg[i] <= pv_reg[i-1];
        end

        nm_reg[5]   <= nm_next;
        neww_reg[5] <= neww_next;
        fg_reg[5]   <= fg_next;
        for (int i = 6; i <= S; i++)
        begin
            nm_reg[i]   <= nm_reg[i-1];
            neww_reg[i] <= neww_reg[i-1];
            fg_reg[i]   <= fg_reg[i-1];
        end

        dev_n_reg <= dev_n_next;
        d2n_reg   <= d2n_next;
        pd_reg    <= pd_next;

        if (stage_valid_reg[S])
        begin
            fifo_mem[wr_ptr_reg] <= result;
        end
    end

    assign foreground   = fifo_mem[rd_ptr_reg].foreground;
    assign mask_valid   = fifo_mem[rd_ptr_reg].mask_valid;
    assign position_out = fifo_mem[rd_ptr_reg].position;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= tgbs_pkg::OCC_W'(tgbs_pkg::FIFO_DEPTH))
        else $error("more transactions in flight than the output queue can hold");

    a_occ_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(stage_valid_reg) + int'(fifo_count_reg)) == int'(occ_reg))
        else $error("in-flight count disagrees with pipeline and queue contents");

    a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && accept) |-> (mem_waddr != mem_raddr))
        else $error("entry read in the same cycle as its write-back");

    a_mask_after_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg[S] && result.mask_valid) |-> seeded_reg)
        else $error("valid mask produced before the seeding frame ended");

    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag cleared outside reset");
`endif

endmodule

`default_nettype wire

// ===== bench/background_mask_checker.sv =====
// ============================================================================
// Background mask checker
// Watches the pixel, mask and register channels of the two-model Gaussian
// background subtractor, predicts every mask transaction from its own copy of
// the per-pixel models and settings, and compares each field in order.
// ============================================================================

module background_mask_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [7:0]                        pixel_value,
    input  logic [tgbs_pkg::POS_W-1:0]        pixel_position,
    input  logic                              frame_end,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              foreground,
    input  logic                              mask_valid,
    input  logic [tgbs_pkg::POS_W-1:0]        position_out,
    input  logic                              cfg_write,
    input  logic [tgbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tgbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                errors,
    output int                                pending
);
    import tgbs_pkg::*;

    typedef struct packed {
        logic [1:0][22:0] variance;
        logic [1:0][15:0] mean;
        logic [1:0][16:0] weight;
    } gauss_pair_t;

    gauss_pair_t pixel_models [int unsigned];
    result_t     mask_expected [$];
    logic        seeded;
    logic [7:0]  match_thr;
    logic [15:0] weight_thr;
    logic [15:0] mean_rate;
    logic [15:0] var_rate;
    logic [15:0] weight_rate;

    function automatic logic [63:0] dev_squared(input logic [15:0] mean, input logic [7:0] u);
        logic [15:0] target;
        logic [63:0] d;
        target = {u, 8'd0};
        d = (mean >= target) ? 64'(mean - target) : 64'(target - mean);
        return d * d;
    endfunction

    function automatic gauss_pair_t fade_and_reward(input gauss_pair_t e, input int sel);
        logic [63:0] keep;
        logic [63:0] w;
        keep = 64'(WEIGHT_ONE) - 64'(weight_rate);
        for (int k = 0; k < 2; k++)
        begin
            w = (e.weight[k] > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(e.weight[k]);
            e.weight[k] = 17'((w * keep) >> 16);
        end
        w = 64'(e.weight[sel]) + 64'(weight_rate);
        e.weight[sel] = (w > 64'(WEIGHT_ONE)) ? WEIGHT_ONE : 17'(w);
        return e;
    endfunction

    function automatic result_t predict_mask(input logic [7:0] u, input logic [POS_W-1:0] pos,
                                             input logic last);
        gauss_pair_t e;
        result_t     r;
        logic [63:0] lim;
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] nm;
        logic [63:0] nv;
        logic        hit;
        int          sel;
        r.foreground = 1'b0;
        r.mask_valid = 1'b0;
        r.position   = pos;
        if (32'(pos) < PIXELS)
        begin
            if (!seeded)
            begin
                e.weight   = {17'd0, WEIGHT_ONE};
                e.mean     = {u, 8'd0, u, 8'd0};
                e.variance = {SEED_VARIANCE, SEED_VARIANCE};
                pixel_models[32'(pos)] = e;
            end
            else
            begin
                e = pixel_models[32'(pos)];
                hit = 1'b0;
                sel = 0;
                for (int q = 0; q < 2; q++)
                begin
                    lim = 64'd2 * 64'(match_thr) * 64'(match_thr) * 64'(e.variance[q]);
                    if (!hit && e.weight[q] != 0 && dev_squared(e.mean[q], u) <= lim)
                    begin
                        hit = 1'b1;
                        sel = q;
                    end
                end
                if (hit)
                begin
                    m  = 64'(e.mean[sel]);
                    v  = 64'(e.variance[sel]);
                    nm = (m * (64'(WEIGHT_ONE) - 64'(mean_rate))
                          + 64'({u, 8'd0}) * 64'(mean_rate) + 64'd32768) >> 16;
                    if (nm > 64'(MEAN_MAX))
                        nm = 64'(MEAN_MAX);
                    nv = ((v * (64'(WEIGHT_ONE) - 64'(var_rate))) << 9)
                         + dev_squared(nm[15:0], u) * 64'(var_rate);
                    nv = (nv + (64'd1 << 24)) >> 25;
                    if (nv > 64'(VARIANCE_MAX))
                        nv = 64'(VARIANCE_MAX);
                    e.mean[sel]     = nm[15:0];
                    e.variance[sel] = nv[22:0];
                    e = fade_and_reward(e, sel);
                end
                else
                begin
                    sel = (e.weight[0] > e.weight[1]) ? 1 : 0;
                    if (e.weight[sel] != 0)
                        e = fade_and_reward(e, sel);
                    e.mean[sel]     = {u, 8'd0};
                    e.variance[sel] = SEED_VARIANCE;
                end
                pixel_models[32'(pos)] = e;
                r.foreground = (e.weight[sel] > {1'b0, weight_thr}) ? 1'b0 : 1'b1;
                r.mask_valid = 1'b1;
            end
        end
        if (!seeded && last)
            seeded = 1'b1;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            pixel_models.delete();
            mask_expected.delete();
            seeded      = 1'b0;
            match_thr   = MATCH_THRESHOLD_RESET;
            weight_thr  = WEIGHT_THRESHOLD_RESET;
            mean_rate   = MEAN_RATE_RESET;
            var_rate    = VARIANCE_RATE_RESET;
            weight_rate = WEIGHT_RATE_RESET;
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MATCH_THRESHOLD:  match_thr   = cfg_data[7:0];
                    REG_WEIGHT_THRESHOLD: weight_thr  = cfg_data;
                    REG_MEAN_RATE:        mean_rate   = cfg_data;
                    REG_VARIANCE_RATE:    var_rate    = cfg_data;
                    REG_WEIGHT_RATE:      weight_rate = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (mask_expected.size() == 0)
                begin
                    $display("%0t: unexpected mask transaction: expected none, actual position %0d",
                             $time, position_out);
                    errors++;
                end
                else
                begin
                    want = mask_expected.pop_front();
                    compare_field("foreground", 32'(want.foreground), 32'(foreground));
                    compare_field("mask_valid", 32'(want.mask_valid), 32'(mask_valid));
                    compare_field("position_out", 32'(want.position), 32'(position_out));
                end
            end
            if (in_valid && in_ready)
            begin
                fresh = predict_mask(pixel_value, pixel_position, frame_end);
                mask_expected.insert(mask_expected.size(), fresh);
            end
            pending = mask_expected.size();
        end
    end

endmodule

// ===== bench/two_gaussian_background_subtractor_core_tb.sv =====
// ============================================================================
// Two-model Gaussian background subtractor testbench
// Seeds a small pool of pixel positions, then streams scene-like pixels
// through several register settings with random idling on both channels,
// while the mask checker predicts and compares every mask transaction.
// ============================================================================

module two_gaussian_background_subtractor_core_tb;
    import tgbs_pkg::*;

    localparam int POOL_SIZE     = 16;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 95;
    localparam int LONG_HOLD     = 64;
    localparam int SETTLE_CYCLES = 2 * STAGES + 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             pixel_value;
    logic [POS_W-1:0]       pixel_position;
    logic                   frame_end;
    logic                   out_valid;
    logic                   out_ready;
    logic                   foreground;
    logic                   mask_valid;
    logic [POS_W-1:0]       position_out;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     outstanding;

    bit                     tail_quiet;
    bit                     sender_steady;
    int                     holds_asked;
    int                     holds_granted;
    logic [POS_W-1:0]       pool [POOL_SIZE];
    logic [7:0]             scene [POOL_SIZE];

    two_gaussian_background_subtractor_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_value    (pixel_value),
        .pixel_position (pixel_position),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .foreground     (foreground),
        .mask_valid     (mask_valid),
        .position_out   (position_out),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    background_mask_checker mask_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_value    (pixel_value),
        .pixel_position (pixel_position),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .foreground     (foreground),
        .mask_valid     (mask_valid),
        .position_out   (position_out),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (mismatches),
        .pending        (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("two_gaussian_background_subtractor_core test failed");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        holds_granted = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_granted != holds_asked)
            begin
                holds_granted++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!tail_quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] value, input logic [POS_W-1:0] pos,
                              input logic last);
        if (!tail_quiet && !sender_steady && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        pixel_value    <= value;
        pixel_position <= pos;
        frame_end      <= last;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_scene_pixel();
        int k;
        int roll;
        int level;
        k = $urandom_range(0, POOL_SIZE - 1);
        roll = $urandom_range(0, 99);
        if (roll < 6)
            scene[k] = 8'($urandom_range(0, 255));
        level = int'(scene[k]);
        if (roll >= 40 && roll < 85)
            level = level + int'($urandom_range(0, 12)) - 6;
        else if (roll >= 85)
            level = int'($urandom_range(0, 255));
        if (level < 0)
            level = 0;
        else if (level > 255)
            level = 255;
        send_pixel(8'(level), pool[k], $urandom_range(0, 31) == 0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] thr, input logic [15:0] wthr,
                                  input logic [15:0] mrate, input logic [15:0] vrate,
                                  input logic [15:0] wrate);
        logic [CFG_DATA_W-1:0]  values [6];
        logic [CFG_INDEX_W-1:0] indexes [6];
        logic [7:0]             junk;
        junk = 8'($urandom_range(0, 255));
        values  = '{{junk, thr}, wthr, mrate, vrate, wrate, {junk, ~thr}};
        indexes = '{REG_MATCH_THRESHOLD, REG_WEIGHT_THRESHOLD, REG_MEAN_RATE,
                    REG_VARIANCE_RATE, REG_WEIGHT_RATE, REG_SPARE};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= indexes[i];
            cfg_data  <= values[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        pixel_value    <= '0;
        pixel_position <= '0;
        frame_end      <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= REG_MATCH_THRESHOLD;
        cfg_data       <= '0;
        tail_quiet     = 1'b0;
        sender_steady  = 1'b0;
        holds_asked    = 0;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool[k]  = POS_W'($urandom_range(0, PIXELS - 1));
            scene[k] = 8'($urandom_range(0, 255));
        end
        pool[0]  = '0;
        pool[1]  = '1;
        pool[2]  = 17'd1;
        pool[3]  = 17'd65536;
        scene[0] = 8'd0;
        scene[1] = 8'd255;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < POOL_SIZE; k++)
            send_pixel(scene[k], pool[k], 1'b0);
        send_pixel(scene[0], pool[0], 1'b1);

        send_pixel(8'd0, pool[0], 1'b0);
        send_pixel(8'd255, pool[1], 1'b0);
        send_pixel(8'd255, pool[0], 1'b0);
        send_pixel(8'd0, pool[1], 1'b1);
        send_pixel(8'd1, pool[0], 1'b0);
        send_pixel(scene[2], pool[2], 1'b0);
        send_pixel(scene[2], pool[2], 1'b0);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_settings(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: apply_settings(8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: apply_settings(8'd16, 16'd32768, 16'd16384, 16'hFFFF, 16'd4096);
                3: apply_settings(MATCH_THRESHOLD_RESET, WEIGHT_THRESHOLD_RESET,
                                  MEAN_RATE_RESET, VARIANCE_RATE_RESET, WEIGHT_RATE_RESET);
                default: apply_settings(8'($urandom_range(0, 255)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 4096)),
                                        16'($urandom_range(0, 8192)),
                                        16'($urandom_range(0, 65535)));
            endcase
            tail_quiet = (phase == PHASES - 1);
            if (phase == 1)
            begin
                holds_asked++;
                sender_steady = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 50)
                    sender_steady = 1'b0;
                send_scene_pixel();
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("two_gaussian_background_subtractor_core test passed");
        else
            $display("two_gaussian_background_subtractor_core test failed");
        $finish;
    end

endmodule
